[sv/hkv_pkg.sv]
// Shared types, constants and state codes for the hashed key-value table.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package hkv_pkg;

    localparam int BUCKETS         = 1024;
    localparam int WAYS            = 4;
    localparam int KEY_BYTES       = 8;
    localparam int VALUE_BITS      = 32;
    localparam int HASH_MUL        = 137;
    localparam int BUCKET_IDX_BITS = 16;
    localparam int CFG_BITS        = 11;
    localparam int CFG_RESET       = 1024;
    localparam int TOTAL_BITS      = 13;

    typedef enum logic [1:0] {
        FN_PUT    = 2'd0,
        FN_GET    = 2'd1,
        FN_REMOVE = 2'd2,
        FN_UNUSED = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISS     = 2'd1,
        ST_FULL     = 2'd2,
        ST_ZERO_LEN = 2'd3
    } t_status;

    // How the back end must treat a queued job
    typedef enum logic [1:0] {
        K_NORMAL   = 2'd0,
        K_ZERO_LEN = 2'd1,
        K_BAD_FUNC = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]            func;
        logic [63:0]           key_bytes;
        logic [3:0]            key_length;
        logic [VALUE_BITS-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] value_out;
        logic [TOTAL_BITS-1:0] entry_total;
    } t_rsp;

    // Classified request handed from front to back
    typedef struct packed {
        t_kind                      kind;
        logic [1:0]                 func;
        logic [63:0]                key;
        logic [3:0]                 len;
        logic [VALUE_BITS-1:0]      value;
        logic [BUCKET_IDX_BITS-1:0] bucket;
    } t_job;

    typedef struct packed {
        logic                  valid;
        logic [3:0]            len;
        logic [63:0]           key;
        logic [VALUE_BITS-1:0] value;
    } t_way;

    typedef enum logic [1:0] {
        F_IDLE = 2'd0,
        F_HASH = 2'd1,
        F_MOD  = 2'd2,
        F_PUSH = 2'd3
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR = 2'd0,
        B_IDLE  = 2'd1,
        B_EVAL  = 2'd2,
        B_RESP  = 2'd3
    } t_back_state;

endpackage

[sv/hashed_key_value_table_core.sv]
// Hashed key-value table. The front end takes a new request only when idle (busy
// low) and stays busy through the byte-serial hash, the 32-step restoring modulo
// and the push into the job queue, which waits while the queue is full.
// Zero-length and unused-function requests skip the hash and modulo steps.
// After reset the bucket memory is cleared one row a cycle (busy high while
// clearing). Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

module hashed_key_value_table_core #(
    parameter int BUCKETS = hkv_pkg::BUCKETS,
    parameter int WAYS    = hkv_pkg::WAYS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  hkv_pkg::t_req                i_req,
    output logic                         o_done,
    output hkv_pkg::t_rsp                o_rsp,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hkv_pkg::CFG_BITS-1:0] i_cfg_data
);

    logic [hkv_pkg::CFG_BITS-1:0] r_bucket_count;

    logic          q_push, q_full, q_pop, q_empty, clearing;
    hkv_pkg::t_job front_job, head_job;

    assign o_cfg_ready = 1'b1;

    // Hold the bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= hkv_pkg::CFG_BITS'(hkv_pkg::CFG_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    hkv_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .i_hold         (clearing),
        .i_bucket_count (r_bucket_count),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_job          (front_job)
    );

    hkv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    hkv_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_job      (head_job),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

endmodule

[sv/hkv_front.sv]
// Front end: takes requests, hashes the key byte by byte, reduces the hash
// modulo the bucket count bit by bit, and pushes a classified job. Uses hkv_pkg.
`timescale 1ns / 1ps

module hkv_front #(
    parameter int BUCKETS = hkv_pkg::BUCKETS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  hkv_pkg::t_req                  i_req,
    input  logic                           i_hold,
    input  logic [hkv_pkg::CFG_BITS-1:0]   i_bucket_count,
    input  logic                           i_q_full,
    output logic                           o_push,
    output hkv_pkg::t_job                  o_job
);

    localparam int NW = $clog2(BUCKETS + 1);

    hkv_pkg::t_front_state r_state, n_state;
    hkv_pkg::t_job         r_job, n_job;
    logic [31:0]           r_h, n_h;
    logic [2:0]            r_idx, n_idx;
    logic [4:0]            r_cnt, n_cnt;
    logic [NW-1:0]         r_rem, n_rem;

    logic          accept;
    logic [31:0]   cfg_ext;
    logic [31:0]   eff_ext;
    logic [NW-1:0] eff_n;
    logic [3:0]    len_sat;
    logic [63:0]   key_masked;
    logic [7:0]    cur_byte;
    logic [NW:0]   trial;
    logic          last_byte;

    assign busy   = (r_state != hkv_pkg::F_IDLE) || i_hold;
    assign accept = start && !busy;

    // Clamp the configured bucket count to 1..BUCKETS
    always_comb begin
        cfg_ext = 32'(i_bucket_count);
        if (cfg_ext == 32'd0) begin
            eff_ext = 32'd1;
        end else if (cfg_ext > 32'(BUCKETS)) begin
            eff_ext = 32'(BUCKETS);
        end else begin
            eff_ext = cfg_ext;
        end
        eff_n = eff_ext[NW-1:0];
    end

    // Saturate the length and drop the unused key bytes
    always_comb begin
        if (i_req.key_length > 4'(hkv_pkg::KEY_BYTES)) begin
            len_sat = 4'(hkv_pkg::KEY_BYTES);
        end else begin
            len_sat = i_req.key_length;
        end
        for (int b = 0; b < 8; b++) begin
            key_masked[b*8 +: 8] = (4'(b) < len_sat) ? i_req.key_bytes[b*8 +: 8] : 8'd0;
        end
    end

    assign cur_byte  = r_job.key[{r_idx, 3'b000} +: 8];
    assign last_byte = (4'(r_idx) + 4'd1) == r_job.len;
    assign trial     = {r_rem, r_h[31]};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hkv_pkg::F_IDLE: begin
                if (accept) begin
                    if (i_req.key_length == 4'd0 || i_req.func == hkv_pkg::FN_UNUSED) begin
                        n_state = hkv_pkg::F_PUSH;
                    end else begin
                        n_state = hkv_pkg::F_HASH;
                    end
                end
            end
            hkv_pkg::F_HASH: begin
                if (last_byte) n_state = hkv_pkg::F_MOD;
            end
            hkv_pkg::F_MOD: begin
                if (r_cnt == 5'd31) n_state = hkv_pkg::F_PUSH;
            end
            hkv_pkg::F_PUSH: begin
                if (!i_q_full) n_state = hkv_pkg::F_IDLE;
            end
            default: n_state = hkv_pkg::F_IDLE;
        endcase
    end

    // Datapath updates and queue push
    always_comb begin
        n_job  = r_job;
        n_h    = r_h;
        n_idx  = r_idx;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        o_push = 1'b0;
        case (r_state)
            hkv_pkg::F_IDLE: begin
                if (accept) begin
                    n_job.func   = i_req.func;
                    n_job.key    = key_masked;
                    n_job.len    = len_sat;
                    n_job.value  = i_req.value_in;
                    n_job.bucket = '0;
                    if (i_req.key_length == 4'd0) begin
                        n_job.kind = hkv_pkg::K_ZERO_LEN;
                    end else if (i_req.func == hkv_pkg::FN_UNUSED) begin
                        n_job.kind = hkv_pkg::K_BAD_FUNC;
                    end else begin
                        n_job.kind = hkv_pkg::K_NORMAL;
                    end
                    n_h   = 32'd0;
                    n_idx = 3'd0;
                end
            end
            hkv_pkg::F_HASH: begin
                n_h   = 32'(r_h * 32'(hkv_pkg::HASH_MUL)) + 32'(cur_byte);
                n_idx = r_idx + 3'd1;
                n_cnt = 5'd0;
                n_rem = '0;
            end
            hkv_pkg::F_MOD: begin
                // One restoring step per cycle, MSB first
                if (trial >= {1'b0, eff_n}) begin
                    n_rem = NW'(trial - {1'b0, eff_n});
                end else begin
                    n_rem = trial[NW-1:0];
                end
                n_h   = {r_h[30:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
            end
            hkv_pkg::F_PUSH: begin
                if (r_job.kind == hkv_pkg::K_NORMAL) begin
                    n_job.bucket = hkv_pkg::BUCKET_IDX_BITS'(r_rem);
                end
                o_push = !i_q_full;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_job = r_job;
        if (r_job.kind == hkv_pkg::K_NORMAL) begin
            o_job.bucket = hkv_pkg::BUCKET_IDX_BITS'(r_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hkv_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_job <= n_job;
        r_h   <= n_h;
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_rem <= n_rem;
    end

endmodule

[sv/hkv_queue.sv]
// Two-entry job queue between front and back ends.
// Depends on hkv_pkg for the job type.
`timescale 1ns / 1ps

module hkv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hkv_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output hkv_pkg::t_job o_job,
    output logic          o_empty
);

    hkv_pkg::t_job r_slot [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_fill;

    assign o_full  = r_fill == 2'd2;
    assign o_empty = r_fill == 2'd0;
    assign o_job   = r_slot[r_rp];

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_slot[r_wp] <= i_job;
    end

endmodule

[sv/hkv_back.sv]
// Back end: clears the bucket memory after reset, then reads one bucket row
// per job, matches the key over all ways, writes the row back when a put or
// remove changes it, and issues the result. Depends on hkv_pkg.
`timescale 1ns / 1ps

module hkv_back #(
    parameter int BUCKETS = hkv_pkg::BUCKETS,
    parameter int WAYS    = hkv_pkg::WAYS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  hkv_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_done,
    output hkv_pkg::t_rsp o_rsp
);

    localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW = $clog2(BUCKETS * WAYS + 1);

    hkv_pkg::t_way [WAYS-1:0] r_mem [BUCKETS];
    hkv_pkg::t_way [WAYS-1:0] r_rd;

    hkv_pkg::t_back_state r_state, n_state;
    hkv_pkg::t_job        r_job;
    logic [AW-1:0]        r_clr;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_done, n_done;
    hkv_pkg::t_rsp        r_rsp, n_rsp;

    logic                     rd_en;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    hkv_pkg::t_way [WAYS-1:0] wr_row;
    logic                     hit_found, free_found;
    logic [WW-1:0]            hit_idx, free_idx;
    logic                     clr_last;

    assign o_clearing = r_state == hkv_pkg::B_CLEAR;
    assign o_done     = r_done;
    assign o_rsp      = r_rsp;
    assign clr_last   = 32'(r_clr) == BUCKETS - 1;
    assign o_pop      = (r_state == hkv_pkg::B_IDLE) && !i_q_empty;
    assign rd_en      = o_pop;

    // Find the matching way and the lowest free way
    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_rd[w].valid) begin
                if (!hit_found && r_rd[w].len == r_job.len && r_rd[w].key == r_job.key) begin
                    hit_found = 1'b1;
                    hit_idx   = WW'(w);
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_idx   = WW'(w);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hkv_pkg::B_CLEAR: begin
                if (clr_last) n_state = hkv_pkg::B_IDLE;
            end
            hkv_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    if (i_job.kind == hkv_pkg::K_NORMAL) begin
                        n_state = hkv_pkg::B_EVAL;
                    end else begin
                        n_state = hkv_pkg::B_RESP;
                    end
                end
            end
            hkv_pkg::B_EVAL: n_state = hkv_pkg::B_IDLE;
            hkv_pkg::B_RESP: n_state = hkv_pkg::B_IDLE;
            default:         n_state = hkv_pkg::B_IDLE;
        endcase
    end

    // Row update, count and result
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_job.bucket[AW-1:0];
        wr_row  = r_rd;
        n_count = r_count;
        n_done  = 1'b0;
        n_rsp.status      = hkv_pkg::ST_MISS;
        n_rsp.value_out   = '0;
        n_rsp.entry_total = hkv_pkg::TOTAL_BITS'(r_count);
        case (r_state)
            hkv_pkg::B_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_row  = '0;
            end
            hkv_pkg::B_EVAL: begin
                n_done = 1'b1;
                case (r_job.func)
                    hkv_pkg::FN_PUT: begin
                        if (hit_found) begin
                            n_rsp.status = hkv_pkg::ST_MISS;
                        end else if (!free_found) begin
                            n_rsp.status = hkv_pkg::ST_FULL;
                        end else begin
                            wr_en                  = 1'b1;
                            wr_row[free_idx].valid = 1'b1;
                            wr_row[free_idx].len   = r_job.len;
                            wr_row[free_idx].key   = r_job.key;
                            wr_row[free_idx].value = r_job.value;
                            n_count                = r_count + CW'(1);
                            n_rsp.status           = hkv_pkg::ST_OK;
                            n_rsp.value_out        = r_job.value;
                        end
                    end
                    hkv_pkg::FN_GET: begin
                        if (hit_found) begin
                            n_rsp.status    = hkv_pkg::ST_OK;
                            n_rsp.value_out = r_rd[hit_idx].value;
                        end
                    end
                    hkv_pkg::FN_REMOVE: begin
                        if (hit_found) begin
                            wr_en                 = 1'b1;
                            wr_row[hit_idx].valid = 1'b0;
                            if (r_count != '0) n_count = r_count - CW'(1);
                            n_rsp.status    = hkv_pkg::ST_OK;
                            n_rsp.value_out = r_rd[hit_idx].value;
                        end
                    end
                    default: ;
                endcase
                n_rsp.entry_total = hkv_pkg::TOTAL_BITS'(n_count);
            end
            hkv_pkg::B_RESP: begin
                n_done = 1'b1;
                if (r_job.kind == hkv_pkg::K_ZERO_LEN) begin
                    n_rsp.status = hkv_pkg::ST_ZERO_LEN;
                end
            end
            default: ;
        endcase
    end

    // Bucket memory: one row written, one row read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_row;
        if (rd_en) r_rd <= r_mem[i_job.bucket[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hkv_pkg::B_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hkv_pkg::B_CLEAR) r_clr <= r_clr + AW'(1);
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_rsp <= n_rsp;
        if (o_pop) r_job <= i_job;
    end

endmodule

[dv/testbench.sv]
// Testbench for the hashed key-value table core: random and directed requests
// checked against an in-bench table model. Depends on hkv_pkg and the core.
`timescale 1ns / 1ps

module testbench;

    localparam int SLOT_TOTAL = hkv_pkg::BUCKETS * hkv_pkg::WAYS;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    hkv_pkg::t_req                 i_req = '0;
    logic                          o_done;
    hkv_pkg::t_rsp                 o_rsp;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [hkv_pkg::CFG_BITS-1:0]  i_cfg_data = '0;

    hashed_key_value_table_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_done(o_done), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Table model state
    logic        tbl_valid [SLOT_TOTAL];
    logic [63:0] tbl_key [SLOT_TOTAL];
    logic [3:0]  tbl_len [SLOT_TOTAL];
    logic [31:0] tbl_value [SLOT_TOTAL];
    int unsigned tbl_count;
    int unsigned bucket_setting;

    hkv_pkg::t_req req_queue[$];
    hkv_pkg::t_rsp rsp_expected[$];
    int   error_count = 0;
    int   beat_index = 0;
    int   gap_left = 0;
    int   burst_left = 0;
    logic taken = 1'b1;

    // Compute the response of one request and update the table
    function automatic hkv_pkg::t_rsp apply_request(hkv_pkg::t_req r);
        hkv_pkg::t_rsp rsp;
        int unsigned   len, n, h, base;
        logic [63:0]   key;
        int            hit, free_slot;
        rsp.status = hkv_pkg::ST_MISS;
        rsp.value_out = '0;
        len = r.key_length;
        hit = -1;
        free_slot = -1;
        key = '0;
        if (len == 0) begin
            rsp.status = hkv_pkg::ST_ZERO_LEN;
        end else if (r.func != hkv_pkg::FN_UNUSED) begin
            if (len > hkv_pkg::KEY_BYTES) len = hkv_pkg::KEY_BYTES;
            key = (len >= 8) ? r.key_bytes : r.key_bytes & ((64'd1 << (len * 8)) - 1);
            n = bucket_setting;
            if (n == 0) n = 1;
            if (n > hkv_pkg::BUCKETS) n = hkv_pkg::BUCKETS;
            h = 0;
            for (int i = 0; i < len; i++) h = h * hkv_pkg::HASH_MUL + key[i*8 +: 8];
            base = (h % n) * hkv_pkg::WAYS;
            for (int w = 0; w < hkv_pkg::WAYS; w++) begin
                if (tbl_valid[base+w]) begin
                    if (hit < 0 && tbl_len[base+w] == len && tbl_key[base+w] == key)
                        hit = base + w;
                end else if (free_slot < 0) begin
                    free_slot = base + w;
                end
            end
            if (r.func == hkv_pkg::FN_PUT) begin
                if (hit >= 0) rsp.status = hkv_pkg::ST_MISS;
                else if (free_slot < 0) rsp.status = hkv_pkg::ST_FULL;
                else begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_key[free_slot] = key;
                    tbl_len[free_slot] = 4'(len);
                    tbl_value[free_slot] = r.value_in;
                    tbl_count++;
                    rsp.status = hkv_pkg::ST_OK;
                    rsp.value_out = r.value_in;
                end
            end else if (hit >= 0) begin
                rsp.status = hkv_pkg::ST_OK;
                rsp.value_out = tbl_value[hit];
                if (r.func == hkv_pkg::FN_REMOVE) begin
                    tbl_valid[hit] = 1'b0;
                    if (tbl_count > 0) tbl_count--;
                end
            end
        end
        rsp.entry_total = tbl_count[hkv_pkg::TOTAL_BITS-1:0];
        return rsp;
    endfunction

    // Driver: present requests in bursts with random gaps, change on falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (req_queue.size() > 0) begin
            i_req <= req_queue.pop_front();
            start <= 1'b1;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(0, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // Track acceptance at the rising edge and predict
    always @(posedge i_clk) begin
        if (start && !busy && i_rst_n) begin
            rsp_expected.push_back(apply_request(i_req));
            beat_index <= beat_index + 1;
            taken <= 1'b1;
        end else if (start) begin
            taken <= 1'b0;
        end else begin
            taken <= 1'b1;
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        hkv_pkg::t_rsp want;
        if (i_rst_n && o_done) begin
            if (rsp_expected.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_rsp);
                error_count++;
            end else begin
                want = rsp_expected.pop_front();
                if (o_rsp.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_rsp.status);
                if (o_rsp.value_out !== want.value_out)
                    $display("%0t: value_out expected %h actual %h", $time,
                             want.value_out, o_rsp.value_out);
                if (o_rsp.entry_total !== want.entry_total)
                    $display("%0t: entry_total expected %0d actual %0d", $time,
                             want.entry_total, o_rsp.entry_total);
                if (o_rsp !== want) error_count++;
            end
        end
    end

    function automatic hkv_pkg::t_req make_req(logic [1:0] f, logic [63:0] k,
                                               logic [3:0] l, logic [31:0] v);
        hkv_pkg::t_req r;
        r.func = f;
        r.key_bytes = k;
        r.key_length = l;
        r.value_in = v;
        return r;
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Write the bucket count through the config channel while idle
    task automatic write_bucket_count(int unsigned value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value[hkv_pkg::CFG_BITS-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        bucket_setting = value[hkv_pkg::CFG_BITS-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued request is accepted and answered
    task automatic drain();
        while (req_queue.size() > 0 || start || rsp_expected.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Fill one phase: mostly put/get/remove over a small pool of keys
    task automatic random_phase(int count, int pool_size);
        logic [63:0] pool_key [16];
        logic [3:0]  pool_len [16];
        int          p;
        logic [1:0]  f;
        logic [3:0]  l;
        logic [63:0] k;
        for (int i = 0; i < 16; i++) begin
            pool_key[i] = rand_key();
            pool_len[i] = 4'($urandom_range(1, 8));
        end
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(0, pool_size - 1);
            f = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 19) == 0) begin
                req_queue.push_back(make_req(2'($urandom_range(0, 3)), rand_key(),
                                             4'($urandom_range(0, 15)), $urandom));
            end else begin
                // Scramble the ignored bytes and sometimes overstate a full length
                k = pool_key[p] ^ (rand_key() << (pool_len[p] * 8));
                l = pool_len[p];
                if (l == 4'd8 && $urandom_range(0, 3) == 0) l = 4'($urandom_range(8, 15));
                req_queue.push_back(make_req(f, k, l, $urandom));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < SLOT_TOTAL; i++) tbl_valid[i] = 1'b0;
        tbl_count = 0;
        bucket_setting = hkv_pkg::CFG_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: every operation, zero length, unused code, long length, full bucket
        write_bucket_count(1);
        req_queue.push_back(make_req(hkv_pkg::FN_GET, 64'h0, 4'd1, 32'h0));
        req_queue.push_back(make_req(hkv_pkg::FN_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,
                                     32'hFFFF_FFFF));
        req_queue.push_back(make_req(hkv_pkg::FN_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15,
                                     32'h1));
        req_queue.push_back(make_req(hkv_pkg::FN_PUT, 64'h0, 4'd1, 32'h0));
        req_queue.push_back(make_req(hkv_pkg::FN_PUT, 64'hAB12, 4'd2, 32'h1234_5678));
        req_queue.push_back(make_req(hkv_pkg::FN_PUT, 64'h0102_0304_0506_0708, 4'd3,
                                     32'h5));
        req_queue.push_back(make_req(hkv_pkg::FN_PUT, 64'h77, 4'd1, 32'h6));
        req_queue.push_back(make_req(hkv_pkg::FN_GET, 64'hFF00_0000_0000_AB12, 4'd2,
                                     32'h0));
        req_queue.push_back(make_req(hkv_pkg::FN_PUT, 64'h5, 4'd0, 32'h9));
        req_queue.push_back(make_req(hkv_pkg::FN_UNUSED, 64'h0, 4'd1, 32'h9));
        req_queue.push_back(make_req(hkv_pkg::FN_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9,
                                     32'h0));
        req_queue.push_back(make_req(hkv_pkg::FN_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,
                                     32'h0));
        req_queue.push_back(make_req(hkv_pkg::FN_GET, 64'h0, 4'd1, 32'h0));
        req_queue.push_back(make_req(hkv_pkg::FN_REMOVE, 64'h0, 4'd1, 32'h0));
        drain();
        write_bucket_count(0);
        req_queue.push_back(make_req(hkv_pkg::FN_GET, 64'hAB12, 4'd2, 32'h0));
        drain();
        write_bucket_count(2047);
        req_queue.push_back(make_req(hkv_pkg::FN_GET, 64'hAB12, 4'd2, 32'h0));
        drain();
        // Random phases over a range of bucket counts
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_bucket_count(3);
                1: write_bucket_count(1024);
                2: write_bucket_count(1);
                3: write_bucket_count($urandom_range(2, 64));
                4: write_bucket_count(2047);
                default: write_bucket_count($urandom_range(0, 2047));
            endcase
            random_phase(310, (ph == 2) ? 8 : 16);
            drain();
        end
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[hashed_key_value_table_core.f]
sv/hkv_pkg.sv
sv/hkv_front.sv
sv/hkv_queue.sv
sv/hkv_back.sv
sv/hashed_key_value_table_core.sv
dv/testbench.sv
